// ===== sv/lth_pkg.sv =====
package lth_pkg;

   localparam int unsigned ALPHA = 26;
   localparam int unsigned BIN_TOTAL = ALPHA * ALPHA * ALPHA;
   localparam int unsigned BIN_WIDTH = 15;
   localparam int unsigned LETTER_WIDTH = 5;
   localparam int unsigned CHAR_WIDTH = 8;
   localparam int unsigned BIN_COUNT_WIDTH = 32;
   localparam int unsigned REQ_DATA_WIDTH = 24;
   localparam int unsigned RSP_DATA_WIDTH = 40;

   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5a;

   localparam logic FUNC_FEED = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_COUNT,
      OP_QUERY
   } lth_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_RESULT
   } lth_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic mem_read;
      logic mem_write;
      logic load_rsp;
   } lth_cmd_type;

   typedef struct packed {
      logic       clear_last;
      lth_op_type op;
      logic       rsp_busy;
   } lth_status_type;

   typedef struct packed {
      logic                    is_letter;
      logic [LETTER_WIDTH-1:0] idx;
   } lth_letter_type;

   function automatic lth_letter_type fold_letter(input logic [CHAR_WIDTH-1:0] ch);
      lth_letter_type r;
      r.is_letter = 1'b0;
      r.idx = '0;
      if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         r.is_letter = 1'b1;
         r.idx = LETTER_WIDTH'(ch - CHAR_LOWER_A);
      end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r.is_letter = 1'b1;
         r.idx = LETTER_WIDTH'(ch - CHAR_UPPER_A);
      end
      return r;
   endfunction

endpackage

// ===== sv/lth_ctrl.sv =====
module lth_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lth_pkg::lth_status_type status,
   output lth_pkg::lth_cmd_type    cmd
);
   import lth_pkg::*;

   lth_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            case (status.op)
               OP_COUNT: state_in = ST_WRITE;
               OP_QUERY: state_in = ST_RESULT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== sv/lth_datapath.sv =====
module lth_datapath #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [lth_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lth_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  lth_pkg::lth_cmd_type                  cmd,
   output lth_pkg::lth_status_type               status
);
   import lth_pkg::*;

   logic [COUNT_WIDTH-1:0] mem [0:BIN_TOTAL-1];

   logic [BIN_WIDTH-1:0]    clr_ff;
   logic [LETTER_WIDTH-1:0] older_ff, newer_ff;
   logic [1:0]              seen_ff;
   lth_op_type              op_ff, op_in;
   logic [BIN_WIDTH-1:0]    addr_ff, addr_in;
   logic                    in_range_ff, in_range_in;
   logic                    enough_ff;
   logic [COUNT_WIDTH-1:0]  rd_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;

   logic [CHAR_WIDTH-1:0]   char_code;
   logic [BIN_WIDTH-1:0]    bin_index;
   lth_letter_type          letter;
   logic [BIN_WIDTH-1:0]    trigram_bin;
   logic [COUNT_WIDTH-1:0]  count_inc;
   logic [COUNT_WIDTH-1:0]  count_val;
   logic [BIN_COUNT_WIDTH-1:0] count_out;

   assign char_code = req_tdata[CHAR_WIDTH-1:0];
   assign bin_index = req_tdata[CHAR_WIDTH +: BIN_WIDTH];
   assign letter = fold_letter(char_code);
   assign trigram_bin = BIN_WIDTH'(older_ff) * BIN_WIDTH'(ALPHA * ALPHA)
                      + BIN_WIDTH'(newer_ff) * BIN_WIDTH'(ALPHA)
                      + BIN_WIDTH'(letter.idx);

   always_comb begin
      op_in = OP_NONE;
      addr_in = trigram_bin;
      in_range_in = 1'b1;
      if (req_tuser == FUNC_READ) begin
         op_in = OP_QUERY;
         addr_in = bin_index;
         in_range_in = (bin_index < BIN_WIDTH'(BIN_TOTAL));
      end else if (letter.is_letter && seen_ff >= 2'd2) begin
         op_in = OP_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         older_ff <= '0;
         newer_ff <= '0;
         seen_ff <= '0;
         op_ff <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.accept) begin
            op_ff <= op_in;
            if (req_tuser == FUNC_FEED && letter.is_letter) begin
               older_ff <= newer_ff;
               newer_ff <= letter.idx;
               if (seen_ff != 2'd3) begin
                  seen_ff <= seen_ff + 1'b1;
               end
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= addr_in;
         in_range_ff <= in_range_in;
         enough_ff <= (seen_ff == 2'd3);
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= RSP_DATA_WIDTH'({enough_ff, count_out});
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mem_write) begin
         mem[addr_ff] <= count_inc;
      end
      if (cmd.mem_read && in_range_ff) begin
         rd_ff <= mem[addr_ff];
      end
   end

   assign count_inc = (&rd_ff) ? rd_ff : rd_ff + 1'b1;
   assign count_val = in_range_ff ? rd_ff : '0;

   generate
      if (COUNT_WIDTH > BIN_COUNT_WIDTH) begin : g_wide
         assign count_out = (|count_val[COUNT_WIDTH-1:BIN_COUNT_WIDTH])
                          ? '1 : count_val[BIN_COUNT_WIDTH-1:0];
      end else if (COUNT_WIDTH == BIN_COUNT_WIDTH) begin : g_equal
         assign count_out = count_val;
      end else begin : g_narrow
         assign count_out = {{(BIN_COUNT_WIDTH-COUNT_WIDTH){1'b0}}, count_val};
      end
   endgenerate

   assign status.clear_last = (clr_ff == BIN_WIDTH'(BIN_TOTAL - 1));
   assign status.op = op_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== sv/letter_trigram_histogram_unit.sv =====
// channel | dir | tdata (low bit up)                      | tuser
// req_    | in  | char_code[7:0], bin_index[22:8], pad     | func (0 feed, 1 read)
// rsp_    | out | bin_count[31:0], enough_letters[32], pad | -
//
// A word that counts nothing passes the accept and read states; a counted letter adds a
// write back after its bin read, and a bin read waits for the result register to empty.
// One word is worked at a time through the histogram memory.
// After reset a clearing pass zeroes all 17576 bins, one per cycle; req_tready stays
// low until the pass is done. A held result does not stop the next word from entering.
module letter_trigram_histogram_unit #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lth_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // char_code, bin_index
   input  logic                               req_tuser,  // func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lth_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata   // bin_count, enough_letters
);
   import lth_pkg::*;

   lth_cmd_type    cmd;
   lth_status_type status;

   lth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lth_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== bench/tb_letter_trigram_histogram_unit.sv =====
module tb_letter_trigram_histogram_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lth_pkg::*;

   localparam int unsigned STALL_LIMIT = 100000;
   localparam int unsigned RANDOM_WORDS = 750;
   localparam logic [BIN_COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic                  func;
      logic [CHAR_WIDTH-1:0] char_code;
      logic [BIN_WIDTH-1:0]  bin_index;
   } req_word_type;

   typedef struct packed {
      logic [BIN_COUNT_WIDTH-1:0] bin_count;
      logic                       enough_letters;
   } bin_read_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   req_word_type pending_words[$];
   bin_read_type expected_reads[$];
   int unsigned words_pushed = 0;
   int unsigned words_taken = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   // shadow copy of the histogram and the letter history
   bit [BIN_COUNT_WIDTH-1:0] trigram_tally [BIN_TOTAL];
   logic [LETTER_WIDTH-1:0]  prior_letter = '0;
   logic [LETTER_WIDTH-1:0]  last_letter = '0;
   logic [1:0]               letter_run = '0;

   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;

   letter_trigram_histogram_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic queue_word(input logic func, input int unsigned ch, input int unsigned bin);
      req_word_type w;
      w.func = func;
      w.char_code = (func == FUNC_FEED) ? CHAR_WIDTH'(ch) : CHAR_WIDTH'($urandom);
      w.bin_index = (func == FUNC_READ) ? BIN_WIDTH'(bin) : BIN_WIDTH'($urandom);
      pending_words.insert(pending_words.size(), w);
      words_pushed++;
   endtask

   task automatic histogram_update(input req_word_type w);
      logic                    is_letter;
      logic [LETTER_WIDTH-1:0] idx;
      int unsigned             bin;
      bin_read_type            r;
      if (w.func == FUNC_FEED) begin
         is_letter = 1'b0;
         idx = '0;
         if (w.char_code >= CHAR_LOWER_A && w.char_code <= CHAR_LOWER_Z) begin
            is_letter = 1'b1;
            idx = LETTER_WIDTH'(w.char_code - CHAR_LOWER_A);
         end else if (w.char_code >= CHAR_UPPER_A && w.char_code <= CHAR_UPPER_Z) begin
            is_letter = 1'b1;
            idx = LETTER_WIDTH'(w.char_code - CHAR_UPPER_A);
         end
         if (is_letter) begin
            if (letter_run >= 2) begin
               bin = int'(prior_letter) * ALPHA * ALPHA + int'(last_letter) * ALPHA + int'(idx);
               if (bin < BIN_TOTAL && trigram_tally[bin] != COUNT_MAX)
                  trigram_tally[bin]++;
            end
            prior_letter = last_letter;
            last_letter = idx;
            if (letter_run < 3)
               letter_run++;
         end
      end else begin
         r.bin_count = (w.bin_index < BIN_TOTAL) ? trigram_tally[w.bin_index] : '0;
         r.enough_letters = (letter_run == 3);
         expected_reads.insert(expected_reads.size(), r);
      end
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin : drive
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0 || pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= w.func;
            req_tdata <= {1'b0, w.bin_index, w.char_code};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: stall pattern switches between always ready, coin flip and mostly stalled
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(16, 96);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   always @(posedge clock) begin : check
      bin_read_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reads.size() == 0) begin
               $error("unexpected result word: bin_count %0d enough_letters %0d",
                      rsp_tdata[31:0], rsp_tdata[32]);
               error_count++;
            end else begin
               e = expected_reads.pop_front();
               if (rsp_tdata[31:0] !== e.bin_count) begin
                  $error("bin_count mismatch: expected %0d, actual %0d",
                         e.bin_count, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[32] !== e.enough_letters) begin
                  $error("enough_letters mismatch: expected %0d, actual %0d",
                         e.enough_letters, rsp_tdata[32]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            histogram_update(req_word_type'{req_tuser, req_tdata[7:0], req_tdata[22:8]});
            words_taken++;
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned ch;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_word(FUNC_READ, 0, 0);
      queue_word(FUNC_FEED, 8'h00, 0);
      queue_word(FUNC_FEED, 8'hff, 0);
      queue_word(FUNC_FEED, CHAR_UPPER_A - 1, 0);
      queue_word(FUNC_FEED, CHAR_UPPER_Z + 1, 0);
      queue_word(FUNC_FEED, CHAR_LOWER_A - 1, 0);
      queue_word(FUNC_FEED, CHAR_LOWER_Z + 1, 0);
      queue_word(FUNC_FEED, CHAR_UPPER_A, 0);
      queue_word(FUNC_FEED, CHAR_LOWER_Z, 0);
      queue_word(FUNC_READ, 0, 25);
      queue_word(FUNC_FEED, CHAR_UPPER_Z, 0);
      queue_word(FUNC_READ, 0, 675);
      queue_word(FUNC_FEED, CHAR_LOWER_A, 0);
      queue_word(FUNC_FEED, CHAR_LOWER_Z, 0);
      queue_word(FUNC_FEED, CHAR_UPPER_Z, 0);
      queue_word(FUNC_READ, 0, 675);
      queue_word(FUNC_READ, 0, BIN_TOTAL - 1);
      queue_word(FUNC_READ, 0, BIN_TOTAL);
      queue_word(FUNC_READ, 0, 32767);
      queue_word(FUNC_READ, 0, 17550);
      queue_word(FUNC_FEED, CHAR_UPPER_Z, 0);
      queue_word(FUNC_READ, 0, BIN_TOTAL - 1);

      // hold off until the directed part has fully drained
      while (words_taken != words_pushed || expected_reads.size() != 0)
         @(posedge clock);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            ch = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 25);
            ch += ($urandom_range(0, 1) == 0) ? CHAR_LOWER_A : CHAR_UPPER_A;
            queue_word(FUNC_FEED, ch, 0);
         end else if (r < 70) begin
            queue_word(FUNC_FEED, $urandom_range(0, 255), 0);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 5)
               queue_word(FUNC_READ, 0, $urandom_range(0, 3) * ALPHA * ALPHA
                          + $urandom_range(0, 3) * ALPHA + $urandom_range(0, 3));
            else if (r < 8)
               queue_word(FUNC_READ, 0, $urandom_range(0, BIN_TOTAL - 1));
            else
               queue_word(FUNC_READ, 0, $urandom_range(0, 32767));
         end
      end

      while (words_taken != words_pushed || expected_reads.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
